// ----- src/rtufr_pkg.sv -----
// RTU frame receiver package: payload structs, event and kind codes, state encoding,
// configuration indexes and the byte-wise CRC-16 step. No dependencies.
package rtufr_pkg;

    localparam int CFG_DATA_W = 12;

    typedef enum logic [1:0] {
        KIND_BYTE = 2'd0,
        KIND_TICK = 2'd1,
        KIND_READ = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        EV_INIT_DONE = 3'd0,
        EV_ACCEPTED  = 3'd1,
        EV_NOT_ADDR  = 3'd2,
        EV_BAD       = 3'd3,
        EV_READ      = 3'd4
    } event_t;

    typedef enum logic [3:0] {
        ST_INIT  = 4'b0001,
        ST_IDLE  = 4'b0010,
        ST_RCV   = 4'b0100,
        ST_ERROR = 4'b1000
    } rx_state_t;

    typedef enum logic {
        CFG_STATION = 1'b0,
        CFG_SILENCE = 1'b1
    } cfg_index_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] rx_byte;
        logic [7:0] read_index;
    } rtufr_in_t;

    typedef struct packed {
        logic [2:0] event_res;
        logic [7:0] frame_address;
        logic [7:0] pdu_length;
        logic [7:0] read_data;
    } rtufr_out_t;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    // One character into the reflected CRC-16, LSB first.
    function automatic logic [15:0] crc16_add(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

// ----- src/rtufr_ram.sv -----
// Generic single-port RAM with registered read data.
// No dependencies.
module rtufr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- src/rtu_frame_receiver_unit.sv -----
// RTU frame receiver top level: receive state machine, silence timer, CRC and result pipe.
// Depends on rtufr_pkg and rtufr_ram.
//
// Usage:
//   s_ channel: one request per cycle while s_ready is high; s_req.kind picks a
//   received character, a time-base tick or a frame store read. Ticks and
//   characters that cause no result only update the state.
//   m_ channel: ready on init timeout, a frame verdict when the silence timer
//   expires after a frame, or the byte asked for by a read.
//   cfg_ channel: station address (index 0) and silence length in ticks (index 1);
//   always ready, to be written while the block is idle.
// Path: a taken request's result passes the result stage and then the output register to m_valid.
// Throughput: one request per cycle unless a stall holds s_ready low. The state machine and
// frame store write settle at the accept edge; the frame store's registered read adds the stage.
// Stalls: a result stage and an output register sit between the channels, so
// with m_ready low two results are held before s_ready drops.
// Reset: state init, timer running from zero, CRC preset, pipe empty. The
// frame store is not cleared; only written positions should be read.
module rtu_frame_receiver_unit
    import rtufr_pkg::*;
#(
    parameter int FRAME_MAX = 256,
    parameter int FRAME_MIN = 4
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  rtufr_in_t             s_req,
    output logic                  m_valid,
    input  logic                  m_ready,
    output rtufr_out_t            m_res,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic                  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int AW = $clog2(FRAME_MAX);
    localparam int CW = $clog2(FRAME_MAX + 1);

    // configuration
    logic [7:0]  station_reg;
    logic [11:0] silence_ticks_reg;

    // receive state
    rx_state_t   rx_state_reg, rx_state_next;
    logic [11:0] silence_count_reg, silence_count_next;
    logic        timer_running_reg, timer_running_next;
    logic [CW-1:0] byte_count_reg, byte_count_next;
    logic [15:0] crc_reg, crc_next;
    logic [7:0]  addr_reg, addr_next;   // copy of frame store position 0

    // result stage (frame store read data joins here)
    logic        p_valid_reg, p_valid_next;
    event_t      p_event_reg, p_event_next;
    logic [7:0]  p_addr_reg, p_addr_next;
    logic [7:0]  p_len_reg, p_len_next;
    logic        p_oor_reg, p_oor_next;

    // output register
    logic        o_valid_reg;
    rtufr_out_t  o_res_reg;

    logic        s_fire, p_adv;
    logic        ram_we, ram_re;
    logic [AW-1:0] ram_addr;
    logic [7:0]  ram_rdata;
    logic [11:0] count_inc;
    logic [CW-1:0] len_diff;
    logic        frame_short;

    assign p_adv     = p_valid_reg && (!o_valid_reg || m_ready);
    assign s_ready   = !p_valid_reg || p_adv;
    assign s_fire    = s_valid && s_ready;
    assign cfg_ready = 1'b1;

    assign count_inc   = (silence_count_reg == 12'hFFF) ? silence_count_reg
                                                        : silence_count_reg + 12'd1;
    assign len_diff    = (byte_count_reg >= CW'(3)) ? byte_count_reg - CW'(3) : '0;
    assign frame_short = byte_count_reg < CW'(FRAME_MIN);

    always_comb begin
        rx_state_next      = rx_state_reg;
        silence_count_next = silence_count_reg;
        timer_running_next = timer_running_reg;
        byte_count_next    = byte_count_reg;
        crc_next           = crc_reg;
        addr_next          = addr_reg;
        p_valid_next       = p_valid_reg && !p_adv;
        p_event_next       = p_event_reg;
        p_addr_next        = p_addr_reg;
        p_len_next         = p_len_reg;
        p_oor_next         = p_oor_reg;
        ram_we             = 1'b0;
        ram_re             = 1'b0;
        ram_addr           = byte_count_reg[AW-1:0];

        if (s_fire) begin
            unique case (s_req.kind)
                KIND_BYTE: begin
                    silence_count_next = '0;
                    timer_running_next = 1'b1;
                    unique case (rx_state_reg)
                        ST_IDLE: begin
                            ram_we          = 1'b1;
                            ram_addr        = '0;
                            addr_next       = s_req.rx_byte;
                            byte_count_next = CW'(1);
                            crc_next        = crc16_add(CRC_INIT, s_req.rx_byte);
                            rx_state_next   = ST_RCV;
                        end
                        ST_RCV: begin
                            if (byte_count_reg < CW'(FRAME_MAX)) begin
                                ram_we          = 1'b1;
                                byte_count_next = byte_count_reg + CW'(1);
                                crc_next        = crc16_add(crc_reg, s_req.rx_byte);
                            end else begin
                                rx_state_next = ST_ERROR;   // overflow, drop frame
                            end
                        end
                        default: ;   // init and error: timer restart only
                    endcase
                end
                KIND_TICK: begin
                    if (timer_running_reg) begin
                        if (count_inc < silence_ticks_reg) begin
                            silence_count_next = count_inc;
                        end else begin
                            // t3.5 expired
                            silence_count_next = '0;
                            timer_running_next = 1'b0;
                            rx_state_next      = ST_IDLE;
                            p_addr_next        = '0;
                            p_len_next         = '0;
                            p_oor_next         = 1'b0;
                            unique case (rx_state_reg)
                                ST_INIT: begin
                                    p_valid_next = 1'b1;
                                    p_event_next = EV_INIT_DONE;
                                end
                                ST_RCV: begin
                                    p_valid_next = 1'b1;
                                    if (frame_short || crc_reg != 16'h0000) begin
                                        p_event_next = EV_BAD;
                                    end else begin
                                        p_addr_next  = addr_reg;
                                        p_len_next   = 8'(len_diff);
                                        p_event_next = (addr_reg == station_reg ||
                                                        addr_reg == 8'h00)
                                                       ? EV_ACCEPTED : EV_NOT_ADDR;
                                    end
                                end
                                default: ;   // idle and error: silent
                            endcase
                        end
                    end
                end
                KIND_READ: begin
                    ram_re       = 1'b1;
                    ram_addr     = s_req.read_index[AW-1:0];
                    p_valid_next = 1'b1;
                    p_event_next = EV_READ;
                    p_addr_next  = '0;
                    p_len_next   = '0;
                    p_oor_next   = 9'(s_req.read_index) >= 9'(FRAME_MAX);
                end
                default: ;   // unused code
            endcase
        end
    end

    rtufr_ram #(
        .WIDTH (8),
        .DEPTH (FRAME_MAX)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .re    (ram_re),
        .addr  (ram_addr),
        .wdata (s_req.rx_byte),
        .rdata (ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            station_reg       <= 8'd1;
            silence_ticks_reg <= 12'd35;
            rx_state_reg      <= ST_INIT;
            silence_count_reg <= '0;
            timer_running_reg <= 1'b1;
            byte_count_reg    <= '0;
            crc_reg           <= CRC_INIT;
            p_valid_reg       <= 1'b0;
            o_valid_reg       <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    CFG_STATION: station_reg       <= cfg_data[7:0];
                    CFG_SILENCE: silence_ticks_reg <= cfg_data[11:0];
                    default: ;
                endcase
            end
            rx_state_reg      <= rx_state_next;
            silence_count_reg <= silence_count_next;
            timer_running_reg <= timer_running_next;
            byte_count_reg    <= byte_count_next;
            crc_reg           <= crc_next;
            p_valid_reg       <= p_valid_next;
            if (p_adv) begin
                o_valid_reg <= 1'b1;
            end else if (m_ready) begin
                o_valid_reg <= 1'b0;
            end
        end
    end

    // payload, no reset
    always_ff @(posedge aclk) begin
        addr_reg    <= addr_next;
        p_event_reg <= p_event_next;
        p_addr_reg  <= p_addr_next;
        p_len_reg   <= p_len_next;
        p_oor_reg   <= p_oor_next;
        if (p_adv) begin
            o_res_reg.event_res     <= p_event_reg;
            o_res_reg.frame_address <= p_addr_reg;
            o_res_reg.pdu_length    <= p_len_reg;
            o_res_reg.read_data     <= (p_event_reg == EV_READ && !p_oor_reg)
                                       ? ram_rdata : 8'h00;
        end
    end

    assign m_valid = o_valid_reg;
    assign m_res   = o_res_reg;

    // checks
    a_timer_idle_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        !timer_running_reg |-> silence_count_reg == 12'd0)
        else $error("silence count not cleared with timer stopped");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        byte_count_reg <= CW'(FRAME_MAX))
        else $error("byte count beyond frame size");

    a_stall_means_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> p_valid_reg && o_valid_reg && !m_ready)
        else $error("request side stalled with room in the pipe");

    a_byte_restarts: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire && s_req.kind == KIND_BYTE |=> timer_running_reg &&
            silence_count_reg == 12'd0)
        else $error("received byte did not restart the silence timer");

    a_dead_tick: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire && s_req.kind == KIND_TICK && !timer_running_reg
            |=> $stable(rx_state_reg) && !timer_running_reg)
        else $error("tick with stopped timer changed the receiver");

endmodule

// ----- dv/rtufr_result_check.sv -----
// Result checker for rtu_frame_receiver_unit: tracks requests and register writes,
// predicts each result that a request yields and compares it with the m_ channel. Uses rtufr_pkg.
`timescale 1ns / 100ps

module rtufr_result_check
    import rtufr_pkg::*;
#(
    parameter int FRAME_MAX = 256,
    parameter int FRAME_MIN = 4
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    input  logic                  s_ready,
    input  rtufr_in_t             s_req,
    input  logic                  m_valid,
    input  logic                  m_ready,
    input  rtufr_out_t            m_res,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic                  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    errors,
    output int                    pending,
    output logic [FRAME_MAX-1:0]  stored_mask,
    output int                    requests_seen,
    output int                    results_seen,
    output int                    verdicts_seen
);

    localparam int MAX_REPORTS = 10;
    localparam logic [15:0] CRC_START = 16'hFFFF;
    localparam logic [15:0] POLY_REFLECTED = 16'hA001;

    logic [7:0]  own_address;
    logic [11:0] silence_len;
    rx_state_t   rx_st;
    logic [11:0] quiet_ticks;
    logic        timer_on;
    logic [8:0]  frame_len;
    logic [15:0] crc_acc;
    logic [7:0]  frame_mem [FRAME_MAX];
    rtufr_out_t  due_results [$];

    function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        repeat (8) c = {1'b0, c[15:1]} ^ (c[0] ? POLY_REFLECTED : 16'h0000);
        return c;
    endfunction

    task automatic add_result(input event_t ev, input logic [7:0] addr,
                              input logic [7:0] len, input logic [7:0] data);
        rtufr_out_t r;
        r.event_res     = ev;
        r.frame_address = addr;
        r.pdu_length    = len;
        r.read_data     = data;
        due_results.push_back(r);
    endtask

    // silence expired: report init completion or the frame verdict; idle and error stay silent
    task automatic close_frame();
        rx_state_t   was;
        logic [7:0]  addr;
        logic [8:0]  len;
        was         = rx_st;
        timer_on    = 1'b0;
        quiet_ticks = '0;
        rx_st       = ST_IDLE;
        if (was == ST_INIT) begin
            add_result(EV_INIT_DONE, 8'h00, 8'h00, 8'h00);
        end else if (was == ST_RCV) begin
            if (frame_len < FRAME_MIN || crc_acc != 16'h0000) begin
                add_result(EV_BAD, 8'h00, 8'h00, 8'h00);
            end else begin
                addr = frame_mem[0];
                len  = (frame_len >= 9'd3) ? frame_len - 9'd3 : 9'd0;
                add_result((addr == own_address || addr == 8'h00) ? EV_ACCEPTED : EV_NOT_ADDR,
                           addr, len[7:0], 8'h00);
            end
        end
    endtask

    task automatic apply_request(input rtufr_in_t r);
        case (r.kind)
            KIND_BYTE: begin
                if (rx_st == ST_IDLE) begin
                    frame_mem[0]   = r.rx_byte;
                    stored_mask[0] = 1'b1;
                    frame_len      = 9'd1;
                    crc_acc        = crc_step(CRC_START, r.rx_byte);
                    rx_st          = ST_RCV;
                end else if (rx_st == ST_RCV) begin
                    if (frame_len < FRAME_MAX) begin
                        frame_mem[frame_len[7:0]]   = r.rx_byte;
                        stored_mask[frame_len[7:0]] = 1'b1;
                        frame_len                   = frame_len + 9'd1;
                        crc_acc                     = crc_step(crc_acc, r.rx_byte);
                    end else begin
                        rx_st = ST_ERROR;
                    end
                end
                quiet_ticks = '0;
                timer_on    = 1'b1;
            end
            KIND_TICK: begin
                if (timer_on) begin
                    if (quiet_ticks != 12'hFFF) quiet_ticks = quiet_ticks + 12'd1;
                    if (quiet_ticks >= silence_len) close_frame();
                end
            end
            KIND_READ: begin
                add_result(EV_READ, 8'h00, 8'h00,
                           (r.read_index < FRAME_MAX) ? frame_mem[r.read_index] : 8'h00);
            end
            default: ;
        endcase
    endtask

    always @(posedge aclk) begin : observe
        rtufr_out_t want;
        logic       wrong;
        if (!aresetn) begin
            own_address   = 8'd1;
            silence_len   = 12'd35;
            rx_st         = ST_INIT;
            quiet_ticks   = '0;
            timer_on      = 1'b1;
            frame_len     = '0;
            crc_acc       = CRC_START;
            stored_mask   = '0;
            due_results.delete();
            errors        = 0;
            requests_seen = 0;
            results_seen  = 0;
            verdicts_seen = 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == CFG_STATION) own_address = cfg_data[7:0];
                else silence_len = cfg_data;
            end
            if (m_valid && m_ready) begin
                results_seen++;
                if (due_results.size() == 0) begin
                    errors++;
                    if (errors <= MAX_REPORTS)
                        $display("%0t: unexpected result ev %0d addr %02h len %0d data %02h",
                                 $realtime, m_res.event_res, m_res.frame_address,
                                 m_res.pdu_length, m_res.read_data);
                end else begin
                    want  = due_results.pop_front();
                    wrong = (m_res.event_res !== want.event_res)
                         || (m_res.frame_address !== want.frame_address)
                         || (m_res.pdu_length !== want.pdu_length)
                         || (m_res.read_data !== want.read_data);
                    if (want.event_res inside {EV_ACCEPTED, EV_NOT_ADDR, EV_BAD})
                        verdicts_seen++;
                    if (wrong) begin
                        errors++;
                        if (errors <= MAX_REPORTS)
                            $display({"%0t: result mismatch, expected ev %0d addr %02h len %0d ",
                                      "data %02h, got ev %0d addr %02h len %0d data %02h"},
                                     $realtime, want.event_res, want.frame_address,
                                     want.pdu_length, want.read_data, m_res.event_res,
                                     m_res.frame_address, m_res.pdu_length, m_res.read_data);
                    end
                end
            end
            if (s_valid && s_ready) begin
                requests_seen++;
                apply_request(s_req);
            end
        end
        pending = due_results.size();
    end

endmodule

// ----- dv/rtu_frame_receiver_unit_test.sv -----
// Testbench top for rtu_frame_receiver_unit: clock, reset, request and result drivers,
// register writes and the final verdict. Depends on rtufr_pkg, rtu_frame_receiver_unit and rtufr_result_check.
`timescale 1ns / 100ps

module rtu_frame_receiver_unit_test;
    import rtufr_pkg::*;

    localparam int FRAME_MAX     = 256;
    localparam int FRAME_MIN     = 4;
    localparam int RESET_CYCLES  = 10;
    localparam int SETTLE_CYCLES = 4;     // margin after the last due result
    localparam int TAIL_CYCLES   = 10;
    localparam int QUIET_LIMIT   = 5000;  // well above the long hold and any random stall
    localparam int HOLD_CYCLES   = 400;
    localparam int RANDOM_BUDGET = 120;
    localparam int IN_W          = $bits(rtufr_in_t);
    localparam logic [1:0]  KIND_UNUSED    = 2'd3;
    localparam logic [15:0] CRC_SEED       = 16'hFFFF;
    localparam logic [15:0] POLY_REFLECTED = 16'hA001;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_valid   = 1'b0;
    logic                  s_ready;
    rtufr_in_t             s_req     = '0;
    logic                  m_valid;
    logic                  m_ready   = 1'b0;
    rtufr_out_t            m_res;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic                  cfg_index = CFG_STATION;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    int                   errors;
    int                   pending;
    int                   requests_seen;
    int                   results_seen;
    int                   verdicts_seen;
    logic [FRAME_MAX-1:0] stored_mask;

    int          send_idle_pct  = 0;
    int          recv_stall_pct = 0;
    int          hold_requests  = 0;
    int          holds_done     = 0;
    int          hold_left      = 0;
    int          quiet_cycles   = 0;
    int          items_sent     = 0;
    logic [7:0]  cur_station    = 8'd1;
    int          cur_silence    = 35;
    logic [7:0]  frame_bytes [$];

    // 10 ns clock: high half, low half
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    rtu_frame_receiver_unit #(
        .FRAME_MAX (FRAME_MAX),
        .FRAME_MIN (FRAME_MIN)
    ) DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_req     (s_req),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_res     (m_res),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    rtufr_result_check #(
        .FRAME_MAX (FRAME_MAX),
        .FRAME_MIN (FRAME_MIN)
    ) u_result_check (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_req         (s_req),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_res         (m_res),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .errors        (errors),
        .pending       (pending),
        .stored_mask   (stored_mask),
        .requests_seen (requests_seen),
        .results_seen  (results_seen),
        .verdicts_seen (verdicts_seen)
    );

    // Result side. A hold request from the stimulus keeps m_ready low while hold_left
    // counts down here, so the block fills up and drops s_ready.
    always @(negedge aclk) begin
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else if (hold_requests != holds_done) begin
            holds_done++;
            hold_left = HOLD_CYCLES - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Watchdog: any handshake on any channel restarts the count.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
        begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("watchdog: no handshake for %0d cycles, %0d results still due",
                         QUIET_LIMIT, pending);
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    // Reference CRC for building frames, bit-serial form.
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        logic        fb;
        c = crc;
        for (int i = 0; i < 8; i++) begin
            fb = c[0] ^ b[i];
            c  = c >> 1;
            if (fb) c = c ^ POLY_REFLECTED;
        end
        return c;
    endfunction

    // Offer one request and hold it until taken; entered and left at a falling edge.
    task automatic push_request(input rtufr_in_t req);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_req   <= req;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        items_sent++;
        @(negedge aclk);
    endtask

    task automatic send_byte(input logic [7:0] b);
        rtufr_in_t r;
        r            = IN_W'($urandom);
        r.kind       = KIND_BYTE;
        r.rx_byte    = b;
        push_request(r);
    endtask

    task automatic send_tick();
        rtufr_in_t r;
        r      = IN_W'($urandom);
        r.kind = KIND_TICK;
        push_request(r);
    endtask

    task automatic send_read(input logic [7:0] idx);
        rtufr_in_t r;
        r            = IN_W'($urandom);
        r.kind       = KIND_READ;
        r.read_index = idx;
        push_request(r);
    endtask

    // first written store position at or after start (wrapping); mask must be non-empty
    function automatic logic [7:0] written_from(input int start);
        int idx;
        idx = start % FRAME_MAX;
        while (!stored_mask[idx]) idx = (idx + 1) % FRAME_MAX;
        return idx[7:0];
    endfunction

    // only positions already written are ever read
    task automatic send_read_any();
        if (stored_mask == '0) return;
        send_read(written_from($urandom_range(FRAME_MAX - 1)));
    endtask

    task automatic let_silence_pass();
        repeat ((cur_silence == 0) ? 1 : cur_silence) send_tick();
    endtask

    task automatic build_frame(input logic [7:0] addr, input int pdu_len);
        logic [15:0] c;
        logic [7:0]  b;
        frame_bytes.delete();
        frame_bytes.push_back(addr);
        c = crc_byte(CRC_SEED, addr);
        repeat (pdu_len) begin
            b = 8'($urandom);
            frame_bytes.push_back(b);
            c = crc_byte(c, b);
        end
        frame_bytes.push_back(c[7:0]);
        frame_bytes.push_back(c[15:8]);
    endtask

    // Gaps are ticks short of the silence length (often one short) and the odd read.
    task automatic send_frame_bytes(input bit with_gaps);
        for (int i = 0; i < frame_bytes.size(); i++) begin
            send_byte(frame_bytes[i]);
            if (with_gaps) begin
                if (cur_silence >= 2 && $urandom_range(9) == 0)
                    repeat ($urandom_range(1) ? cur_silence - 1 : $urandom_range(cur_silence - 1))
                        send_tick();
                if ($urandom_range(9) == 0) send_read_any();
            end
        end
    endtask

    // more than FRAME_MAX characters: receiver goes to error, frame dropped silently
    task automatic overflow_frame();
        frame_bytes.delete();
        repeat (FRAME_MAX + $urandom_range(1, 4)) frame_bytes.push_back(8'($urandom));
        frame_bytes[0] = cur_station;
        send_frame_bytes(1'b0);
        let_silence_pass();
    endtask

    task automatic random_burst();
        int         pick;
        int         sel;
        int         pos;
        logic [7:0] addr;
        rtufr_in_t  r;
        pick = $urandom_range(99);
        sel  = $urandom_range(9);
        addr = (sel < 4) ? cur_station : (sel < 6) ? 8'h00 : 8'($urandom);
        if (pick < 72) begin
            // well-formed frame; a share of them gets one bit flipped
            build_frame(addr, ($urandom_range(19) == 0) ? $urandom_range(100, 253)
                                                         : $urandom_range(0, 12));
            if (pick >= 60) begin
                pos = $urandom_range(frame_bytes.size() - 1);
                frame_bytes[pos] = frame_bytes[pos] ^ (8'h01 << $urandom_range(7));
            end
            send_frame_bytes(1'b1);
            let_silence_pass();
        end else if (pick < 80) begin
            frame_bytes.delete();
            repeat ($urandom_range(1, 3)) frame_bytes.push_back(8'($urandom));
            send_frame_bytes(1'b1);
            let_silence_pass();
        end else if (pick < 90) begin
            repeat ($urandom_range(1, 4)) send_read_any();
        end else begin
            // noise: any kind, any content, but reads only of written positions
            repeat ($urandom_range(1, 6)) begin
                r = IN_W'($urandom);
                if (r.kind == KIND_READ) begin
                    if (stored_mask == '0) r.kind = KIND_TICK;
                    else r.read_index = written_from(int'(r.read_index));
                end
                push_request(r);
            end
        end
    endtask

    task automatic run_random(input int budget);
        int stop;
        stop = items_sent + budget;
        while (items_sent < stop) random_burst();
        let_silence_pass();
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        @(negedge aclk);
        cfg_valid <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    // Registers change only with nothing in flight.
    task automatic set_phase(input logic [7:0] station, input int silence,
                             input int idle_pct, input int stall_pct);
        wait_drained();
        write_reg(CFG_STATION, CFG_DATA_W'(station));
        write_reg(CFG_SILENCE, silence[CFG_DATA_W-1:0]);
        cur_station    = station;
        cur_silence    = silence;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
    endtask

    initial begin : stimulus
        rtufr_in_t r;

        repeat (RESET_CYCLES) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed: one-tick silence so each case costs few requests.
        set_phase(8'd1, 1, 0, 0);
        send_byte(8'h00);               // init: only restarts the timer
        r            = '0;
        r.kind       = KIND_UNUSED;     // unused kind, no result
        r.rx_byte    = 8'hFF;
        r.read_index = 8'hFF;
        push_request(r);
        send_tick();                    // init expiry -> ready
        send_tick();                    // timer stopped, ignored
        build_frame(8'h00, 1);          // broadcast, accepted
        send_frame_bytes(1'b0);
        send_tick();
        send_read(8'd0);
        send_read(8'd3);
        build_frame(8'hFF, 1);          // other station
        send_frame_bytes(1'b0);
        send_tick();
        build_frame(8'h01, 0);          // good CRC but below minimum length
        send_frame_bytes(1'b0);
        send_tick();
        build_frame(8'h01, 1);          // CRC broken
        frame_bytes[3] = frame_bytes[3] ^ 8'h80;
        send_frame_bytes(1'b0);
        send_tick();

        // reset-value silence, no idling; overflow first so every position gets written
        set_phase(8'd1, 35, 0, 0);
        overflow_frame();
        run_random(RANDOM_BUDGET);

        // longest silence: a frame to the highest station stays open through a few
        // ticks and is closed by the first tick of the next phase
        set_phase(8'd247, 4095, 0, 0);
        build_frame(8'd247, 2);
        send_frame_bytes(1'b0);
        repeat (20) send_tick();
        send_read_any();

        // zero silence: every running tick expires; receiver stalls
        set_phase(8'($urandom_range(2, 246)), 0, 0, 63);
        run_random(RANDOM_BUDGET);

        // long hold while reads keep coming, then light idling on both sides
        set_phase(8'd247, 3, 7, 7);
        hold_requests++;
        repeat (40) send_read_any();
        overflow_frame();
        run_random(RANDOM_BUDGET);

        // sender idles
        set_phase(8'($urandom_range(1, 247)), $urandom_range(1, 8), 63, 0);
        run_random(RANDOM_BUDGET);

        wait_drained();
        repeat (TAIL_CYCLES) @(negedge aclk);
        $display("Covered %0d requests and %0d results, %0d of them frame verdicts.",
                 requests_seen, results_seen, verdicts_seen);
        $display("Silence 0/1/3/35 and random plus an open frame under 4095, stations 1/247/random, stalls and a hold.");
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
